@@ rtl/typed_value_byte_serializer_macros.svh @@
// ----------------------------------------------------------------------------
// typed_value_byte_serializer_macros
// Assertion helpers for the serializer RTL.
// ----------------------------------------------------------------------------
`ifndef TYPED_VALUE_BYTE_SERIALIZER_MACROS_SVH
`define TYPED_VALUE_BYTE_SERIALIZER_MACROS_SVH

// Same-cycle implication, off during reset.
`define TVBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("serializer check failed");

// Next-cycle implication, off during reset.
`define TVBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("serializer check failed");

`endif

@@ rtl/tvbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvbs_pkg
// Types and constants for the typed value byte serializer.
// ----------------------------------------------------------------------------
package tvbs_pkg;

  localparam int MaxBytes = 10;
  localparam int CntW     = $clog2(MaxBytes + 1);

  typedef logic [CntW-1:0]             cnt_t;
  typedef logic [MaxBytes-1:0][7:0]    bytes_t;

  typedef enum logic [2:0] {
    CMD_S8     = 3'd0,
    CMD_U8     = 3'd1,
    CMD_S16    = 3'd2,
    CMD_I32    = 3'd3,
    CMD_I64    = 3'd4,
    CMD_UVAR   = 3'd5,
    CMD_ZIGZAG = 3'd6
  } cmd_e;

  // One encoded item: bytes in wire order from index 0, count of valid bytes.
  typedef struct packed {
    bytes_t bytes;
    cnt_t   cnt;
    logic   err;
  } enc_t;

endpackage

@@ rtl/tvbs_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvbs_encoder
// Input register and wire-byte encoding of one typed value.
// ----------------------------------------------------------------------------
module tvbs_encoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          cmd_i,
  input  logic signed [63:0]  value_i,
  output logic                enc_valid_o,
  input  logic                enc_take_i,
  output tvbs_pkg::enc_t      enc_o
);

  logic              valid_q, valid_d;
  logic [2:0]        cmd_q;
  logic [63:0]       value_q;
  logic              accept;
  logic [63:0]       vw;
  logic [tvbs_pkg::MaxBytes-1:0][6:0] grp;
  tvbs_pkg::cnt_t    vcnt;
  logic              s8_ok, u8_ok, s16_ok;

  assign in_stall_o  = valid_q && !enc_take_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign enc_valid_o = valid_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (enc_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      value_q <= value_i;
    end
  end

  // Range checks on the full 64-bit signed value.
  assign s8_ok  = (&value_q[63:7])  || !(|value_q[63:7]);
  assign u8_ok  = !(|value_q[63:8]);
  assign s16_ok = (&value_q[63:15]) || !(|value_q[63:15]);

  // Zigzag map: (v << 1) ^ sign fill.
  assign vw = (cmd_q == tvbs_pkg::CMD_ZIGZAG) ?
              ((value_q << 1) ^ {64{value_q[63]}}) : value_q;

  always_comb begin
    for (int i = 0; i < tvbs_pkg::MaxBytes - 1; i++) begin
      grp[i] = vw[7*i +: 7];
    end
    grp[tvbs_pkg::MaxBytes-1] = {6'b0, vw[63]};
    // Length is one past the highest nonzero group, at least one byte.
    vcnt = tvbs_pkg::cnt_t'(1);
    for (int i = 1; i < tvbs_pkg::MaxBytes; i++) begin
      if (grp[i] != 7'd0) begin
        vcnt = tvbs_pkg::cnt_t'(i + 1);
      end
    end
  end

  always_comb begin
    enc_o = '0;
    unique case (cmd_q) inside
      tvbs_pkg::CMD_S8, tvbs_pkg::CMD_U8: begin
        if ((cmd_q == tvbs_pkg::CMD_S8) ? s8_ok : u8_ok) begin
          enc_o.bytes[0] = value_q[7:0];
        end else begin
          enc_o.err = 1'b1;
        end
        enc_o.cnt = tvbs_pkg::cnt_t'(1);
      end
      tvbs_pkg::CMD_S16: begin
        if (s16_ok) begin
          enc_o.bytes[0] = value_q[15:8];
          enc_o.bytes[1] = value_q[7:0];
          enc_o.cnt      = tvbs_pkg::cnt_t'(2);
        end else begin
          enc_o.err = 1'b1;
          enc_o.cnt = tvbs_pkg::cnt_t'(1);
        end
      end
      tvbs_pkg::CMD_I32: begin
        for (int i = 0; i < 4; i++) begin
          enc_o.bytes[i] = value_q[8*(3-i) +: 8];
        end
        enc_o.cnt = tvbs_pkg::cnt_t'(4);
      end
      tvbs_pkg::CMD_I64: begin
        for (int i = 0; i < 8; i++) begin
          enc_o.bytes[i] = value_q[8*(7-i) +: 8];
        end
        enc_o.cnt = tvbs_pkg::cnt_t'(8);
      end
      tvbs_pkg::CMD_UVAR, tvbs_pkg::CMD_ZIGZAG: begin
        // Continuation bit on every byte ahead of the last.
        for (int i = 0; i < tvbs_pkg::MaxBytes; i++) begin
          enc_o.bytes[i] = {(tvbs_pkg::cnt_t'(i + 1) < vcnt), grp[i]};
        end
        enc_o.cnt = vcnt;
      end
      default: begin
        // Unused selector: drop, no bytes.
        enc_o.cnt = '0;
      end
    endcase
  end

endmodule

@@ rtl/typed_value_byte_serializer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_value_byte_serializer
// Encodes typed values (fixed-size big-endian or varint) into wire bytes.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o   | cmd_i, value_i
//   out     | output    | out_valid_o / out_stall_i | byte_out_o, last_o, range_error_o
//
// One output byte per cycle while out_stall_i is low: an item holds the byte buffer
// until all of its bytes are sent, 0 to 10 (an error result or a byte type has 1, a varint
// up to 10, an unused selector none). The single output byte register sets this.
// Path: input register, byte buffer, output byte register. A new item enters while
// the last byte of the previous one is sent. Reset clears all valid state. Output
// stall holds the buffer and back-pressures the input through in_stall_o.
// ----------------------------------------------------------------------------
`include "typed_value_byte_serializer_macros.svh"

module typed_value_byte_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          cmd_i,
  input  logic signed [63:0]  value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          byte_out_o,
  output logic                last_o,
  output logic                range_error_o
);

  tvbs_pkg::enc_t   enc;
  logic             enc_valid;
  logic             take;
  logic             pop;
  logic             out_free;

  tvbs_pkg::bytes_t bytes_q, bytes_d;
  tvbs_pkg::cnt_t   cnt_q, cnt_d;
  logic             err_q, err_d;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic             rerr_q, rerr_d;

  tvbs_encoder u_encoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .enc_valid_o (enc_valid),
    .enc_take_i  (take),
    .enc_o       (enc)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop      = (cnt_q != '0) && out_free;
  // Load the next item once the buffer is empty or its last byte leaves now.
  assign take     = enc_valid &&
                    ((cnt_q == '0) || ((cnt_q == tvbs_pkg::cnt_t'(1)) && pop));

  always_comb begin
    cnt_d   = cnt_q;
    bytes_d = bytes_q;
    err_d   = err_q;
    if (take) begin
      cnt_d   = enc.cnt;
      bytes_d = enc.bytes;
      err_d   = enc.err;
    end else if (pop) begin
      cnt_d   = cnt_q - tvbs_pkg::cnt_t'(1);
      bytes_d = {8'h00, bytes_q[tvbs_pkg::MaxBytes-1:1]};
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    last_d      = last_q;
    rerr_d      = rerr_q;
    if (pop) begin
      out_valid_d = 1'b1;
      byte_d      = bytes_q[0];
      last_d      = (cnt_q == tvbs_pkg::cnt_t'(1));
      rerr_d      = err_q;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    err_q   <= err_d;
    byte_q  <= byte_d;
    last_q  <= last_d;
    rerr_q  <= rerr_d;
  end

  assign out_valid_o   = out_valid_q;
  assign byte_out_o    = byte_q;
  assign last_o        = last_q;
  assign range_error_o = rerr_q;

  `TVBS_ASSERT_IMP(a_err_is_last, clk_i, rst_ni, out_valid_o && range_error_o, last_o)
  `TVBS_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= tvbs_pkg::cnt_t'(tvbs_pkg::MaxBytes))
  `TVBS_ASSERT_NXT(a_cnt_step, clk_i, rst_ni, pop && (cnt_q > tvbs_pkg::cnt_t'(1)), (cnt_q + tvbs_pkg::cnt_t'(1)) == $past(cnt_q))
  `TVBS_ASSERT_NXT(a_pop_shows, clk_i, rst_ni, pop, out_valid_o && (last_o == ($past(cnt_q) == tvbs_pkg::cnt_t'(1))))

endmodule

@@ test/typed_value_byte_serializer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_value_byte_serializer_tb
// Drives typed values into the serializer and checks every wire byte.
// A short table covers range limits, error cases and the longest varints.
// Random values follow, mostly in range for the byte and short types and of
// varied bit length for the varints. Both sides pause at random.
// ----------------------------------------------------------------------------
module typed_value_byte_serializer_tb;

  localparam logic [2:0] CMD_UNUSED  = 3'd7;
  localparam int         NumDirected = 26;
  localparam int         NumRandom   = 94;
  localparam int         QuietTail   = 15;
  localparam int         DrainCycles = 20;
  localparam int         CycleLimit  = 400_000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } wire_beat_t;

  // A row with fixed set gives one result that is typed in; the rest go
  // through the encoder model.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] value;
    logic        fixed;
    logic [7:0]  data;
    logic        err;
  } dir_row_t;

  localparam dir_row_t DirectedRows [NumDirected] = '{
    '{tvbs_pkg::CMD_S8,     64'h0000_0000_0000_007F, 1'b1, 8'h7F, 1'b0},
    '{tvbs_pkg::CMD_S8,     64'hFFFF_FFFF_FFFF_FF80, 1'b1, 8'h80, 1'b0},
    '{tvbs_pkg::CMD_S8,     64'h0000_0000_0000_0080, 1'b1, 8'h00, 1'b1},
    '{tvbs_pkg::CMD_S8,     64'hFFFF_FFFF_FFFF_FF7F, 1'b1, 8'h00, 1'b1},
    '{tvbs_pkg::CMD_S8,     64'h8000_0000_0000_0000, 1'b1, 8'h00, 1'b1},
    '{tvbs_pkg::CMD_U8,     64'h0000_0000_0000_0000, 1'b1, 8'h00, 1'b0},
    '{tvbs_pkg::CMD_U8,     64'h0000_0000_0000_00FF, 1'b1, 8'hFF, 1'b0},
    '{tvbs_pkg::CMD_U8,     64'h0000_0000_0000_0100, 1'b1, 8'h00, 1'b1},
    '{tvbs_pkg::CMD_U8,     64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'h00, 1'b1},
    '{tvbs_pkg::CMD_S16,    64'h0000_0000_0000_7FFF, 1'b0, 8'h00, 1'b0},
    '{tvbs_pkg::CMD_S16,    64'hFFFF_FFFF_FFFF_8000, 1'b0, 8'h00, 1'b0},
    '{tvbs_pkg::CMD_S16,    64'h0000_0000_0000_8000, 1'b1, 8'h00, 1'b1},
    '{tvbs_pkg::CMD_S16,    64'hFFFF_FFFF_FFFF_7FFF, 1'b1, 8'h00, 1'b1},
    '{tvbs_pkg::CMD_I32,    64'hDEAD_BEEF_1234_5678, 1'b0, 8'h00, 1'b0},
    '{tvbs_pkg::CMD_I64,    64'h8000_0000_0000_0000, 1'b0, 8'h00, 1'b0},
    '{tvbs_pkg::CMD_I64,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00, 1'b0},
    '{tvbs_pkg::CMD_UVAR,   64'h0000_0000_0000_0000, 1'b1, 8'h00, 1'b0},
    '{tvbs_pkg::CMD_UVAR,   64'h0000_0000_0000_007F, 1'b1, 8'h7F, 1'b0},
    '{tvbs_pkg::CMD_UVAR,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'h00, 1'b0},
    '{tvbs_pkg::CMD_UVAR,   64'h8000_0000_0000_0000, 1'b0, 8'h00, 1'b0},
    '{tvbs_pkg::CMD_UVAR,   64'h0100_0000_0000_0000, 1'b0, 8'h00, 1'b0},
    '{tvbs_pkg::CMD_ZIGZAG, 64'h0000_0000_0000_0000, 1'b1, 8'h00, 1'b0},
    '{tvbs_pkg::CMD_ZIGZAG, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'h01, 1'b0},
    '{tvbs_pkg::CMD_ZIGZAG, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 8'h00, 1'b0},
    '{tvbs_pkg::CMD_ZIGZAG, 64'h8000_0000_0000_0000, 1'b0, 8'h00, 1'b0},
    '{CMD_UNUSED,           64'h1234_5678_9ABC_DEF0, 1'b0, 8'h00, 1'b0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         cmd_i;
  logic signed [63:0] value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [7:0]         byte_out_o;
  logic               last_o;
  logic               range_error_o;

  wire_beat_t pending_beats[$];
  int         fail_count;
  int         items_sent;
  int         beats_checked;
  int         errors_seen;
  int         cycle_count;
  bit         quiet;

  typed_value_byte_serializer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .byte_out_o   (byte_out_o),
    .last_o       (last_o),
    .range_error_o(range_error_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d beats still due", cycle_count,
               pending_beats.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void push_beat(input logic [7:0] data, input logic last,
                                    input logic err);
    wire_beat_t b;
    b.data = data;
    b.last = last;
    b.err  = err;
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  function automatic void push_big_endian(input logic [63:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) begin
      push_beat(v[8*i +: 8], i == 0, 1'b0);
    end
  endfunction

  function automatic void push_varint(input logic [63:0] v);
    logic [63:0] rest;
    logic [6:0]  grp;
    bit          done;
    rest = v;
    done = 1'b0;
    while (!done) begin
      grp  = rest[6:0];
      rest = rest >> 7;
      if (rest == 64'd0) begin
        push_beat({1'b0, grp}, 1'b1, 1'b0);
        done = 1'b1;
      end else begin
        push_beat({1'b1, grp}, 1'b0, 1'b0);
      end
    end
  endfunction

  // Range checks treat the value as a full 64-bit signed number.
  function automatic void encode_value(input logic [2:0] cmd, input logic [63:0] v);
    logic        neg;
    logic [63:0] mag;
    neg = v[63];
    mag = ~v + 64'd1;
    case (cmd)
      tvbs_pkg::CMD_S8: begin
        if (neg ? (mag > 64'd128) : (v > 64'd127)) push_beat(8'h00, 1'b1, 1'b1);
        else push_big_endian(v, 1);
      end
      tvbs_pkg::CMD_U8: begin
        if (neg || v > 64'd255) push_beat(8'h00, 1'b1, 1'b1);
        else push_big_endian(v, 1);
      end
      tvbs_pkg::CMD_S16: begin
        if (neg ? (mag > 64'd32768) : (v > 64'd32767)) push_beat(8'h00, 1'b1, 1'b1);
        else push_big_endian(v, 2);
      end
      tvbs_pkg::CMD_I32:    push_big_endian(v, 4);
      tvbs_pkg::CMD_I64:    push_big_endian(v, 8);
      tvbs_pkg::CMD_UVAR:   push_varint(v);
      tvbs_pkg::CMD_ZIGZAG: push_varint((v << 1) ^ {64{neg}});
      default: ;
    endcase
  endfunction

  // Mostly in-range values for the byte and short types; varied bit lengths
  // otherwise so the varints span every size.
  function automatic logic [63:0] pick_value(input logic [2:0] cmd);
    logic [63:0] full;
    int          sel;
    full = {$urandom, $urandom};
    sel  = $urandom_range(0, 9);
    if (sel < 5 && cmd == tvbs_pkg::CMD_S8) begin
      return 64'(longint'($urandom_range(0, 255)) - 128);
    end
    if (sel < 5 && cmd == tvbs_pkg::CMD_U8) begin
      return 64'($urandom_range(0, 255));
    end
    if (sel < 5 && cmd == tvbs_pkg::CMD_S16) begin
      return 64'(longint'($urandom_range(0, 65535)) - 32768);
    end
    case (sel)
      5, 6:    return full >> $urandom_range(0, 63);
      7:       return ~(full >> $urandom_range(0, 63));
      8:       return full;
      default: return 64'(longint'($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  task automatic send_item(input logic [2:0] cmd, input logic [63:0] value,
                           input logic fixed, input logic [7:0] data,
                           input logic err);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i      = cmd;
    value_i    = value;
    do @(posedge clk_i); while (in_stall_o);
    if (fixed) push_beat(data, 1'b1, err);
    else encode_value(cmd, value);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_beats.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    wire_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("unexpected beat", 64'({last_o, range_error_o, byte_out_o}),
                        64'd0);
      end else begin
        want = pending_beats.pop_front();
        if (byte_out_o !== want.data) begin
          report_mismatch("byte", 64'(byte_out_o), 64'(want.data));
        end
        if (last_o !== want.last) begin
          report_mismatch("last", 64'(last_o), 64'(want.last));
        end
        if (range_error_o !== want.err) begin
          report_mismatch("range_error", 64'(range_error_o), 64'(want.err));
        end
        beats_checked++;
        if (range_error_o) errors_seen++;
      end
    end
  end

  // Output back-pressure in bursts, with stall-free stretches in between.
  initial begin
    int  stall_left;
    bit  stalls_on;
    out_stall_i = 1'b0;
    stall_left  = 0;
    stalls_on   = 1'b1;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 63) == 0) stalls_on = !stalls_on;
      if (quiet || !rst_ni) begin
        out_stall_i = 1'b0;
        stall_left  = 0;
      end else if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        stall_left  = $urandom_range(1, 10) - 1;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  initial begin
    logic [2:0] cmd;
    int         random_done;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = '0;
    value_i     = '0;
    quiet       = 1'b0;
    fail_count  = 0;
    items_sent  = 0;
    random_done = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DirectedRows[i]) begin
      send_item(DirectedRows[i].cmd, DirectedRows[i].value, DirectedRows[i].fixed,
                DirectedRows[i].data, DirectedRows[i].err);
    end
    wait_drained();

    while (random_done < NumRandom) begin
      cmd = 3'($urandom_range(0, 7));
      quiet = (random_done >= NumRandom - QuietTail);
      send_item(cmd, pick_value(cmd), 1'b0, 8'h00, 1'b0);
      random_done++;
      // hold the sender until everything due has come out
      if (random_done == NumRandom / 2) wait_drained();
    end
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);

    if (pending_beats.size() != 0) begin
      report_mismatch("beats never delivered", 64'(pending_beats.size()), 64'd0);
    end
    $display("Sent %0d items (%0d from the table), checked %0d beats, %0d range errors.",
             items_sent, NumDirected, beats_checked, errors_seen);
    $display("Covered all seven types, range limits, 10-byte varints and both-side stalls.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
